[hw/rtl/nds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_pkg
// Shared constants, codes and control bundles of the diffusion step unit.
// ----------------------------------------------------------------------------
package nds_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int MEM_AW    = COL_W + 1;           // bank bit + column
   localparam int MEM_DEPTH = 2 ** MEM_AW;

   localparam int PIX_W   = 16;
   localparam int WORD_W  = 2 * PIX_W;             // {conductance, level}
   localparam int DIM_W   = 11;
   localparam int STEP_W  = 24;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 24;

   localparam int ACC_W   = 36;                    // sum of four flux terms
   localparam int SPLIT   = 18;                    // low part of sum for step product
   localparam int TOT_W   = 64;
   localparam int FRAC_SH = 32;

   localparam logic [CSR_AW-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_STEP_SIZE    = 2'd2;

   localparam logic [1:0] TERM_LEFT  = 2'd0;
   localparam logic [1:0] TERM_RIGHT = 2'd1;
   localparam logic [1:0] TERM_UP    = 2'd2;
   localparam logic [1:0] TERM_DOWN  = 2'd3;

   typedef struct packed {
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr_a;
      logic [MEM_AW-1:0] rd_addr_b;
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
   } nds_mem_cmd_type;

   typedef struct packed {
      logic       capture_input;
      logic       capture_center;
      logic       mac_en;
      logic [1:0] term;
      logic       term_en;
      logic       mul_lo;
      logic       mul_hi;
      logic       finish;
      logic       out_load;
      logic       out_last;
      logic       clear;
   } nds_dp_cmd_type;

endpackage

[hw/rtl/nds_line_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_line_store
// Two row banks of {conductance, level}; one write port, two registered reads.
// ----------------------------------------------------------------------------
module nds_line_store import nds_pkg::*; (
   input  logic                  clock,
   input  nds_mem_cmd_type       mem_cmd,
   input  logic [WORD_W-1:0]     wr_data,
   output logic [WORD_W-1:0]     rd_data_a,
   output logic [WORD_W-1:0]     rd_data_b
);

   logic [WORD_W-1:0] mem_ff [MEM_DEPTH];
   logic [WORD_W-1:0] rd_a_ff;
   logic [WORD_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_ff[mem_cmd.wr_addr] <= wr_data;
      end
   end

   // read data holds between reads; the MAC steps rely on that
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_a_ff <= mem_ff[mem_cmd.rd_addr_a];
         rd_b_ff <= mem_ff[mem_cmd.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hw/rtl/nds_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_datapath
// Flux multiply-accumulate, step product, rounding/saturation, result word.
// ----------------------------------------------------------------------------
module nds_datapath import nds_pkg::*; (
   input  logic                clock,
   input  logic [WORD_W-1:0]   req_tdata,
   input  logic [STEP_W-1:0]   step_size,
   input  nds_dp_cmd_type      dp_cmd,
   input  logic [WORD_W-1:0]   rd_data_a,
   input  logic [WORD_W-1:0]   rd_data_b,
   output logic [WORD_W-1:0]   wr_data,
   output logic [PIX_W-1:0]    rsp_tdata,
   output logic                rsp_tlast
);

   logic [PIX_W-1:0]          lin_ff, cin_ff;
   logic [PIX_W-1:0]          lh_ff, ch_ff;
   logic [WORD_W-1:0]         up_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [TOT_W-1:0]   tot_ff, tot_in;
   logic [PIX_W-1:0]          res_ff, res_in;
   logic [PIX_W-1:0]          out_level_ff;
   logic                      out_last_ff;

   logic [WORD_W-1:0]         nb_word;
   logic [PIX_W:0]            csum;
   logic signed [PIX_W:0]     diff;
   logic signed [2*PIX_W+2:0] prod;

   logic [SPLIT-1:0]                 s_lo;
   logic signed [ACC_W-SPLIT-1:0]    s_hi;
   logic [SPLIT+STEP_W-1:0]          prod_lo;
   logic signed [ACC_W-SPLIT+STEP_W:0] prod_hi;
   logic [TOT_W-1:0]                 base_word;

   always_comb begin
      unique case (dp_cmd.term)
         TERM_LEFT:  nb_word = rd_data_a;
         TERM_RIGHT: nb_word = rd_data_b;
         TERM_UP:    nb_word = up_ff;
         TERM_DOWN:  nb_word = {cin_ff, lin_ff};
      endcase
   end

   assign csum = {1'b0, ch_ff} + {1'b0, nb_word[WORD_W-1:PIX_W]};
   assign diff = $signed({1'b0, nb_word[PIX_W-1:0]}) - $signed({1'b0, lh_ff});
   assign prod = $signed({1'b0, csum}) * diff;

   always_comb begin
      acc_in = acc_ff;
      if (dp_cmd.capture_input) begin
         acc_in = '0;
      end else if (dp_cmd.mac_en && dp_cmd.term_en) begin
         acc_in = acc_ff + ACC_W'(prod);
      end
   end

   // sum * step split in two partial products
   assign s_lo      = acc_ff[SPLIT-1:0];
   assign s_hi      = $signed(acc_ff[ACC_W-1:SPLIT]);
   assign prod_lo   = s_lo * step_size;
   assign prod_hi   = s_hi * $signed({1'b0, step_size});
   // level in the integer part, plus half an output LSB for rounding
   assign base_word = TOT_W'({lh_ff, {FRAC_SH{1'b0}}}) | (TOT_W'(1) << (FRAC_SH - 1));

   always_comb begin
      tot_in = tot_ff;
      if (dp_cmd.mul_lo) begin
         tot_in = $signed(base_word) + $signed(TOT_W'(prod_lo));
      end else if (dp_cmd.mul_hi) begin
         tot_in = tot_ff + (TOT_W'(prod_hi) <<< SPLIT);
      end
   end

   always_comb begin
      if (tot_ff[TOT_W-1]) begin
         res_in = '0;
      end else if (|tot_ff[TOT_W-2:FRAC_SH+PIX_W]) begin
         res_in = '1;
      end else begin
         res_in = tot_ff[FRAC_SH+PIX_W-1:FRAC_SH];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture_input) begin
         lin_ff <= req_tdata[PIX_W-1:0];
         cin_ff <= req_tdata[WORD_W-1:PIX_W];
      end
      if (dp_cmd.capture_center) begin
         lh_ff <= rd_data_a[PIX_W-1:0];
         ch_ff <= rd_data_a[WORD_W-1:PIX_W];
         up_ff <= rd_data_b;
      end
      acc_ff <= acc_in;
      tot_ff <= tot_in;
      if (dp_cmd.finish) begin
         res_ff <= res_in;
      end
      if (dp_cmd.out_load) begin
         out_level_ff <= res_ff;
         out_last_ff  <= dp_cmd.out_last;
      end
   end

   assign wr_data   = dp_cmd.clear ? '0 : {cin_ff, lin_ff};
   assign rsp_tdata = out_level_ff;
   assign rsp_tlast = out_last_ff;

endmodule

[hw/rtl/nds_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_ctrl
// Sequencer: clearing pass, raster counters, per-pixel step schedule.
// ----------------------------------------------------------------------------
module nds_ctrl import nds_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [DIM_W-1:0]   image_width,
   input  logic [DIM_W-1:0]   image_height,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output nds_mem_cmd_type    mem_cmd,
   output nds_dp_cmd_type     dp_cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RD_C   = 4'd2;
   localparam logic [3:0] S_RD_S   = 4'd3;
   localparam logic [3:0] S_MAC_L  = 4'd4;
   localparam logic [3:0] S_MAC_R  = 4'd5;
   localparam logic [3:0] S_MAC_U  = 4'd6;
   localparam logic [3:0] S_MAC_D  = 4'd7;
   localparam logic [3:0] S_MUL_LO = 4'd8;
   localparam logic [3:0] S_MUL_HI = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              bank_ff, bank_in;
   logic              have_frame_ff, have_frame_in;
   logic [MEM_AW-1:0] clr_ff, clr_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic              emit_ff, emit_in;
   logic              col_last_ff, col_last_in;
   logic              row_last_ff, row_last_in;
   logic              frame_last_ff, frame_last_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [COL_W-1:0]  wm1, c_sel, col_prev, col_next;
   logic [ROW_W-1:0]  hm1, r_sel;
   logic              emit, has_up, out_free;

   // last column / row index after clamping to [2, MAX]
   always_comb begin
      if (image_width < DIM_W'(2)) begin
         wm1 = COL_W'(1);
      end else if (32'(image_width) > MAX_WIDTH) begin
         wm1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         wm1 = COL_W'(image_width - DIM_W'(1));
      end
      if (image_height < DIM_W'(2)) begin
         hm1 = ROW_W'(1);
      end else if (32'(image_height) > MAX_HEIGHT) begin
         hm1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         hm1 = ROW_W'(image_height - DIM_W'(1));
      end
   end

   assign c_sel    = (col_ff <= wm1) ? col_ff : wm1;
   assign r_sel    = (row_ff <= hm1) ? row_ff : hm1;
   assign emit     = (r_sel != '0) || have_frame_ff;
   assign has_up   = (cur_row_ff > ROW_W'(1)) || (cur_row_ff == '0);
   assign col_prev = cur_col_ff - COL_W'(1);
   assign col_next = cur_col_ff + COL_W'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      bank_in       = bank_ff;
      have_frame_in = have_frame_ff;
      clr_in        = clr_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      emit_in       = emit_ff;
      col_last_in   = col_last_ff;
      row_last_in   = row_last_ff;
      frame_last_in = frame_last_ff;
      mem_cmd       = '0;
      dp_cmd        = '0;
      dp_cmd.out_last = frame_last_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = clr_ff;
            dp_cmd.clear    = 1'b1;
            clr_in          = clr_ff + MEM_AW'(1);
            if (clr_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.capture_input = 1'b1;
               cur_col_in    = c_sel;
               cur_row_in    = r_sel;
               emit_in       = emit;
               col_last_in   = (c_sel == wm1);
               row_last_in   = (r_sel == hm1);
               frame_last_in = (r_sel == '0) && (c_sel == wm1);
               state_in      = emit ? S_RD_C : S_FIN;
            end
         end
         S_RD_C: begin
            mem_cmd.rd_en     = 1'b1;
            mem_cmd.rd_addr_a = {~bank_ff, cur_col_ff};   // row r-1, center
            mem_cmd.rd_addr_b = {bank_ff, cur_col_ff};    // row r-2, above
            state_in          = S_RD_S;
         end
         S_RD_S: begin
            dp_cmd.capture_center = 1'b1;
            mem_cmd.rd_en     = 1'b1;
            mem_cmd.rd_addr_a = {~bank_ff, col_prev};
            mem_cmd.rd_addr_b = {~bank_ff, col_next};
            state_in          = S_MAC_L;
         end
         S_MAC_L: begin
            dp_cmd.mac_en  = 1'b1;
            dp_cmd.term    = TERM_LEFT;
            dp_cmd.term_en = (cur_col_ff != '0);
            state_in       = S_MAC_R;
         end
         S_MAC_R: begin
            dp_cmd.mac_en  = 1'b1;
            dp_cmd.term    = TERM_RIGHT;
            dp_cmd.term_en = !col_last_ff;
            state_in       = S_MAC_U;
         end
         S_MAC_U: begin
            dp_cmd.mac_en  = 1'b1;
            dp_cmd.term    = TERM_UP;
            dp_cmd.term_en = has_up;
            state_in       = S_MAC_D;
         end
         S_MAC_D: begin
            dp_cmd.mac_en  = 1'b1;
            dp_cmd.term    = TERM_DOWN;
            dp_cmd.term_en = (cur_row_ff != '0);
            state_in       = S_MUL_LO;
         end
         S_MUL_LO: begin
            dp_cmd.mul_lo = 1'b1;
            state_in      = S_MUL_HI;
         end
         S_MUL_HI: begin
            dp_cmd.mul_hi = 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            dp_cmd.finish   = 1'b1;
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = {bank_ff, cur_col_ff};
            if (col_last_ff) begin
               col_in  = '0;
               bank_in = ~bank_ff;
               if (row_last_ff) begin
                  row_in        = '0;
                  have_frame_in = 1'b1;
               end else begin
                  row_in = cur_row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_next;
               row_in = cur_row_ff;
            end
            state_in = emit_ff ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (out_free) begin
               dp_cmd.out_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         col_ff        <= '0;
         row_ff        <= '0;
         bank_ff       <= 1'b0;
         have_frame_ff <= 1'b0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         bank_ff       <= bank_in;
         have_frame_ff <= have_frame_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff    <= cur_col_in;
      cur_row_ff    <= cur_row_in;
      emit_ff       <= emit_in;
      col_last_ff   <= col_last_in;
      row_last_ff   <= row_last_in;
      frame_last_ff <= frame_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result word raised outside output state");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_tready) |=> state_ff == S_OUT)
      else $error("pending result overwritten while stalled");

   a_frame_sticky: assert property (@(posedge clock) disable iff (reset)
      have_frame_ff |=> have_frame_ff)
      else $error("frame-seen flag dropped");

   a_no_emit_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid && !emit) |=> state_ff == S_FIN)
      else $error("pixel without result did not go straight to store");

endmodule

[hw/rtl/nonlinear_diffusion_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonlinear_diffusion_step_unit
// One explicit 5-point nonlinear diffusion step on a raster pixel stream.
// ----------------------------------------------------------------------------
// Each input word carries a pixel's level (Q0.16) and conductance (Q1.15).
// For every accepted pixel (r, c) the unit emits the new level of pixel
// (r-1, c): L + 0.5*step*sum over in-image 4-neighbours of (c_here+c_nb) *
// (L_nb-L_here), rounded to nearest (ties up) and saturated to 16 bits.
// Results trail the input by one row; the last row of a frame comes out
// while row 0 of the next frame streams in, and tlast marks its last pixel.
// Row 0 of the first frame after reset gives no results. A pixel that
// yields a result goes through two line-store reads, four multiply-accumulate
// steps for the flux terms, two partial-product steps for the step-size
// multiply, store and output load; a pixel without a result goes straight
// to store. The next pixel is accepted while a result still waits on the
// rsp side. After reset the line stores are cleared, one entry per cycle,
// all 2 * MAX_WIDTH = 2048 entries, before req_tready rises; the csr port
// accepts writes during that time. Write csr only between pixels.
// ----------------------------------------------------------------------------
module nonlinear_diffusion_step_unit import nds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // csr write port: index 0 image_width, 1 image_height, 2 step_size
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata,
   // pixel input
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [WORD_W-1:0]   req_tdata,   // [15:0] level_in, [31:16] conductance
   // result output
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [PIX_W-1:0]    rsp_tdata,   // [15:0] level_out
   output logic                rsp_tlast    // frame_last
);

   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [STEP_W-1:0] step_ff;

   nds_mem_cmd_type   mem_cmd;
   nds_dp_cmd_type    dp_cmd;
   logic [WORD_W-1:0] wr_data, rd_data_a, rd_data_b;

   // config registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1024);
         height_ff <= DIM_W'(1024);
         step_ff   <= STEP_W'(16384);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_STEP_SIZE:    step_ff   <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencing, raster counters, handshakes
   nds_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .mem_cmd      (mem_cmd),
      .dp_cmd       (dp_cmd)
   );

   // arithmetic and result register
   nds_datapath u_datapath (
      .clock     (clock),
      .req_tdata (req_tdata),
      .step_size (step_ff),
      .dp_cmd    (dp_cmd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_data   (wr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // two row banks, ping-ponged per row
   nds_line_store u_line_store (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .wr_data   (wr_data),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule
